// File: rtl/mbrs_pkg.sv
// shared constants, types and codes for the masked beta ratio summarizer
package mbrs_pkg;

    localparam int MAX_STATES      = 32;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int CNT_W           = 32;
    localparam int SUM_W           = RATIO_FRAC_BITS + 33;
    localparam int MEAN_W          = 17;
    localparam int BIN_W           = 5;
    localparam int NST_W           = 6;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int DVS_W           = 33;
    localparam int QUO_W           = MEAN_W + 1;
    localparam int STEP_W          = 5;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 6;

    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [MEAN_W-1:0] ONE_RATIO = MEAN_W'(1) << RATIO_FRAC_BITS;

    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BINARY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STATE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_MASK_MODE  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_STATES = 1'd1;

    localparam logic FUNC_SITE   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [MEAN_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: rtl/masked_beta_ratio_summarizer.sv
// top level: site counters, per-bin stores, sequencer and summary output
// a covered site item waits for the shared divider, an uncovered one does not
// a finish item reads each bin in turn and runs the divider only for bins with overlap
// rows leave one per strobe on o_valid and cannot be stalled; busy is high while working
// synchronous active-low reset clears counters and marks all bins empty at once
// bins are also marked empty in the same cycle as the last summary row shows on o_valid
module masked_beta_ratio_summarizer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mbrs_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [mbrs_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_func,
    input  logic [mbrs_pkg::CNT_W-1:0]            i_meth_count,
    input  logic [mbrs_pkg::CNT_W-1:0]            i_unmeth_count,
    input  logic                                  i_mask_bit,
    input  logic [mbrs_pkg::BIN_W-1:0]            i_state_index,
    output logic                                  o_valid,
    output logic [mbrs_pkg::BIN_W-1:0]            o_bin_id,
    output logic [mbrs_pkg::CNT_W-1:0]            o_universe_count,
    output logic [mbrs_pkg::CNT_W-1:0]            o_query_count,
    output logic [mbrs_pkg::CNT_W-1:0]            o_mask_count,
    output logic [mbrs_pkg::CNT_W-1:0]            o_overlap_count,
    output logic [mbrs_pkg::MEAN_W-1:0]           o_mean_ratio,
    output logic [mbrs_pkg::STATUS_W-1:0]         o_status,
    output logic                                  o_last
);
    import mbrs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SDIV = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_MDIV = 3'd5;

    logic [2:0]        r_state;
    logic [MODE_W-1:0] r_mode;
    logic [NST_W-1:0]  r_nst;

    logic [SUM_W-1:0]  r_sum [MAX_STATES];
    logic [CNT_W-1:0]  r_ovl [MAX_STATES];
    logic [CNT_W-1:0]  r_mem [MAX_STATES];
    logic [MAX_STATES-1:0] r_vld;

    logic [SUM_W-1:0]  r_rd_sum;
    logic [CNT_W-1:0]  r_rd_ovl;
    logic [CNT_W-1:0]  r_rd_mem;

    logic [CNT_W-1:0]  r_site_total;
    logic [CNT_W-1:0]  r_cov_total;
    logic              r_corrupt;

    logic [BIN_W-1:0]  r_bin;
    logic              r_add_mem;
    logic              r_add_cov;
    logic [BIN_W-1:0]  r_row;
    logic [BIN_W-1:0]  r_last_row;

    logic              accept;
    logic              covered;
    logic [NST_W-1:0]  limit;
    logic              idx_ok;
    logic              n_add_mem;
    logic              n_add_cov;
    logic [BIN_W-1:0]  n_bin;
    logic [BIN_W-1:0]  rd_addr;
    logic              emit;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]  n_ovl;
    logic [CNT_W-1:0]  n_mem;

    t_div_req div_req;
    t_div_rsp div_rsp;

    mbrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign busy    = r_state != S_IDLE;
    assign accept  = start && !busy;
    assign covered = (i_meth_count | i_unmeth_count) != '0;

    always_comb begin
        limit = r_nst;
        if (limit == '0) begin
            limit = NST_W'(1);
        end else if (limit > NST_W'(MAX_STATES)) begin
            limit = NST_W'(MAX_STATES);
        end
    end

    assign idx_ok = NST_W'(i_state_index) < limit;

    always_comb begin
        n_bin     = '0;
        n_add_mem = 1'b0;
        n_add_cov = 1'b0;
        case (r_mode)
            MODE_BINARY: begin
                n_add_mem = i_mask_bit;
                n_add_cov = i_mask_bit && covered;
            end
            MODE_STATE: begin
                n_bin     = i_state_index;
                n_add_mem = idx_ok;
                n_add_cov = idx_ok && covered;
            end
            default: begin
                n_add_cov = covered;
            end
        endcase
    end

    assign rd_addr = (r_state == S_IDLE) ? n_bin :
                     (r_state == S_SDIV || r_state == S_UPD) ? r_bin : r_row;
    assign emit    = (r_state == S_CHK && r_rd_ovl == '0) ||
                     (r_state == S_MDIV && div_rsp.done);

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = SUM_W'({i_meth_count, RATIO_FRAC_BITS'(0)});
        div_req.divisor  = DVS_W'(i_meth_count) + DVS_W'(i_unmeth_count);
        if (r_state == S_IDLE) begin
            div_req.start = accept && i_func == FUNC_SITE && n_add_cov;
        end else begin
            div_req.dividend = r_rd_sum;
            div_req.divisor  = DVS_W'(r_rd_ovl);
            div_req.start    = r_state == S_CHK && r_rd_ovl != '0;
        end
    end

    assign sum_add = {1'b0, r_rd_sum} + (SUM_W + 1)'(div_rsp.quotient);
    assign n_sum   = r_add_cov ? (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]) : r_rd_sum;
    assign n_ovl   = (r_add_cov && r_rd_ovl != CNT_MAX) ? r_rd_ovl + 1'b1 : r_rd_ovl;
    assign n_mem   = (r_add_mem && r_rd_mem != CNT_MAX) ? r_rd_mem + 1'b1 : r_rd_mem;

    always_ff @(posedge i_clk) begin
        r_rd_sum <= r_vld[rd_addr] ? r_sum[rd_addr] : '0;
        r_rd_ovl <= r_vld[rd_addr] ? r_ovl[rd_addr] : '0;
        r_rd_mem <= r_vld[rd_addr] ? r_mem[rd_addr] : '0;
        if ((r_state == S_SDIV && div_rsp.done) || r_state == S_UPD) begin
            r_sum[r_bin] <= n_sum;
            r_ovl[r_bin] <= n_ovl;
            r_mem[r_bin] <= n_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_func == FUNC_SITE) begin
            r_bin     <= n_bin;
            r_add_mem <= n_add_mem;
            r_add_cov <= n_add_cov;
        end
        if (emit) begin
            o_bin_id         <= r_row;
            o_universe_count <= r_site_total;
            o_query_count    <= r_cov_total;
            o_mask_count     <= r_rd_mem;
            o_overlap_count  <= r_rd_ovl;
            o_mean_ratio     <= (r_rd_ovl == '0) ? '0 : div_rsp.quotient;
            o_status         <= r_corrupt ? ST_CORRUPT :
                                (r_rd_ovl == '0) ? ST_EMPTY : ST_OK;
            o_last           <= r_row == r_last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NONE;
            r_nst        <= NST_W'(1);
            r_state      <= S_IDLE;
            r_vld        <= '0;
            r_site_total <= '0;
            r_cov_total  <= '0;
            r_corrupt    <= 1'b0;
            r_row        <= '0;
            r_last_row   <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= emit;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MASK_MODE:  r_mode <= i_cfg_wdata[MODE_W-1:0];
                    REG_NUM_STATES: r_nst  <= i_cfg_wdata[NST_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_func == FUNC_FINISH) begin
                            r_row      <= '0;
                            r_last_row <= (r_mode == MODE_STATE) ? BIN_W'(limit - 1'b1) : '0;
                            r_state    <= S_RD;
                        end else begin
                            if (r_site_total != CNT_MAX) begin
                                r_site_total <= r_site_total + 1'b1;
                            end
                            if (covered && r_cov_total != CNT_MAX) begin
                                r_cov_total <= r_cov_total + 1'b1;
                            end
                            if (r_mode == MODE_STATE && !idx_ok) begin
                                r_corrupt <= 1'b1;
                            end
                            if (n_add_cov) begin
                                r_state <= S_SDIV;
                            end else if (n_add_mem) begin
                                r_state <= S_UPD;
                            end
                        end
                    end
                end
                S_SDIV: begin
                    if (div_rsp.done) begin
                        r_vld[r_bin] <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_UPD: begin
                    r_vld[r_bin] <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK, S_MDIV: begin
                    if (r_state == S_CHK && r_rd_ovl != '0) begin
                        r_state <= S_MDIV;
                    end else if (emit) begin
                        if (r_row == r_last_row) begin
                            r_vld        <= '0;
                            r_site_total <= '0;
                            r_cov_total  <= '0;
                            r_corrupt    <= 1'b0;
                            r_state      <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/mbrs_div.sv
// iterative restoring divider, one quotient bit per cycle, result capped at one
module mbrs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbrs_pkg::t_div_req i_req,
    output mbrs_pkg::t_div_rsp o_rsp
);
    import mbrs_pkg::*;

    localparam int LO_W  = QUO_W;
    localparam int HI_W  = SUM_W - LO_W;
    localparam int REM_W = DVS_W + 1;

    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [LO_W-1:0]   r_lo;
    logic [QUO_W-1:0]  r_q;
    logic              r_ovf;
    logic [STEP_W-1:0] r_cnt;
    logic              r_done;

    logic [REM_W-1:0]  trial;
    logic              take;
    logic              ovf_now;

    assign trial   = {r_rem, r_lo[LO_W-1]};
    assign take    = trial >= REM_W'(r_dvs);
    assign ovf_now = DVS_W'(i_req.dividend[SUM_W-1:LO_W]) >= i_req.divisor;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvs <= i_req.divisor;
            r_rem <= DVS_W'(i_req.dividend[SUM_W-1:LO_W]);
            r_lo  <= i_req.dividend[LO_W-1:0];
            r_q   <= '0;
            r_ovf <= ovf_now;
        end else if (r_cnt != '0) begin
            r_rem <= take ? DVS_W'(trial - REM_W'(r_dvs)) : DVS_W'(trial);
            r_lo  <= {r_lo[LO_W-2:0], 1'b0};
            r_q   <= {r_q[QUO_W-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= STEP_W'(QUO_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = (r_ovf || r_q > QUO_W'(ONE_RATIO)) ? ONE_RATIO
                                                               : r_q[MEAN_W-1:0];

endmodule

// File: test/tb_top.sv
// self-checking testbench for the masked beta ratio summarizer
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbrs_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 45;
    localparam int RANDOM_ITEMS  = 420;

    typedef struct packed {
        logic              func;
        logic [CNT_W-1:0]  meth;
        logic [CNT_W-1:0]  unmeth;
        logic              mbit;
        logic [BIN_W-1:0]  sidx;
    } t_site_cmd;

    typedef struct packed {
        logic [BIN_W-1:0]    bin;
        logic [CNT_W-1:0]    universe;
        logic [CNT_W-1:0]    query;
        logic [CNT_W-1:0]    members;
        logic [CNT_W-1:0]    overlap;
        logic [MEAN_W-1:0]   mean;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_summary_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_func = 1'b0;
    logic [CNT_W-1:0]      i_meth_count = '0;
    logic [CNT_W-1:0]      i_unmeth_count = '0;
    logic                  i_mask_bit = 1'b0;
    logic [BIN_W-1:0]      i_state_index = '0;
    logic                  o_valid;
    logic [BIN_W-1:0]      o_bin_id;
    logic [CNT_W-1:0]      o_universe_count;
    logic [CNT_W-1:0]      o_query_count;
    logic [CNT_W-1:0]      o_mask_count;
    logic [CNT_W-1:0]      o_overlap_count;
    logic [MEAN_W-1:0]     o_mean_ratio;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_last;

    masked_beta_ratio_summarizer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_meth_count     (i_meth_count),
        .i_unmeth_count   (i_unmeth_count),
        .i_mask_bit       (i_mask_bit),
        .i_state_index    (i_state_index),
        .o_valid          (o_valid),
        .o_bin_id         (o_bin_id),
        .o_universe_count (o_universe_count),
        .o_query_count    (o_query_count),
        .o_mask_count     (o_mask_count),
        .o_overlap_count  (o_overlap_count),
        .o_mean_ratio     (o_mean_ratio),
        .o_status         (o_status),
        .o_last           (o_last)
    );

    always #1 i_clk = ~i_clk;

    t_site_cmd    items_to_send[$];
    t_summary_row rows_due[$];
    int           n_queued = 0;
    int           n_accepted = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;

    // summarizer state as predicted
    logic [MODE_W-1:0] cur_mode;
    logic [NST_W-1:0]  cur_nstates;
    logic [SUM_W-1:0]  acc_ratio[MAX_STATES];
    logic [CNT_W-1:0]  acc_overlap[MAX_STATES];
    logic [CNT_W-1:0]  acc_members[MAX_STATES];
    logic [CNT_W-1:0]  n_sites;
    logic [CNT_W-1:0]  n_covered;
    logic              bad_state_seen;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic int unsigned bin_count(logic [NST_W-1:0] ns);
        if (ns < 1) return 1;
        if (ns > MAX_STATES) return MAX_STATES;
        return ns;
    endfunction

    function automatic void clear_bins();
        for (int k = 0; k < MAX_STATES; k++) begin
            acc_ratio[k]   = '0;
            acc_overlap[k] = '0;
            acc_members[k] = '0;
        end
        n_sites        = '0;
        n_covered      = '0;
        bad_state_seen = 1'b0;
    endfunction

    function automatic void add_coverage(int unsigned b, logic [63:0] ratio);
        logic [63:0] total;
        acc_overlap[b] = sat_inc(acc_overlap[b]);
        total = 64'(acc_ratio[b]) + ratio;
        acc_ratio[b] = (total > 64'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : total[SUM_W-1:0];
    endfunction

    function automatic void add_to_bin(int unsigned b, logic covered, logic [63:0] ratio);
        acc_members[b] = sat_inc(acc_members[b]);
        if (covered) add_coverage(b, ratio);
    endfunction

    function automatic void tally_site(t_site_cmd c);
        logic [63:0] depth;
        logic [63:0] ratio;
        logic        covered;
        depth   = 64'(c.meth) + 64'(c.unmeth);
        covered = (depth != 0);
        ratio   = covered ? ((64'(c.meth) << RATIO_FRAC_BITS) / depth) : 64'd0;
        n_sites = sat_inc(n_sites);
        if (covered) n_covered = sat_inc(n_covered);
        if (cur_mode == MODE_BINARY) begin
            if (c.mbit) add_to_bin(0, covered, ratio);
        end else if (cur_mode == MODE_STATE) begin
            if (c.sidx < bin_count(cur_nstates)) add_to_bin(c.sidx, covered, ratio);
            else bad_state_seen = 1'b1;
        end else if (covered) begin
            add_coverage(0, ratio);
        end
    endfunction

    function automatic void summarize_bins();
        int unsigned  nrows;
        logic [63:0]  mean;
        t_summary_row r;
        nrows = (cur_mode == MODE_STATE) ? bin_count(cur_nstates) : 1;
        for (int k = 0; k < nrows; k++) begin
            mean = 0;
            if (acc_overlap[k] != 0) begin
                mean = 64'(acc_ratio[k]) / 64'(acc_overlap[k]);
                if (mean > 64'(ONE_RATIO)) mean = 64'(ONE_RATIO);
            end
            r.bin      = BIN_W'(k);
            r.universe = n_sites;
            r.query    = n_covered;
            r.members  = acc_members[k];
            r.overlap  = acc_overlap[k];
            r.mean     = mean[MEAN_W-1:0];
            if (bad_state_seen) r.status = ST_CORRUPT;
            else if (acc_overlap[k] == 0) r.status = ST_EMPTY;
            else r.status = ST_OK;
            r.last = (k == nrows - 1);
            rows_due.push_back(r);
        end
        clear_bins();
    endfunction

    // predictor: register writes and accepted items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode    = MODE_NONE;
            cur_nstates = NST_W'(1);
            clear_bins();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MASK_MODE:  cur_mode = i_cfg_wdata[MODE_W-1:0];
                    REG_NUM_STATES: cur_nstates = i_cfg_wdata[NST_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                n_accepted++;
                if (i_func == FUNC_FINISH) begin
                    summarize_bins();
                end else begin
                    tally_site('{i_func, i_meth_count, i_unmeth_count, i_mask_bit,
                                 i_state_index});
                end
            end
        end
    end

    // driver
    t_site_cmd drv_cmd;
    int        burst_left = 1;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (items_to_send.size() > 0) begin
                drv_cmd = items_to_send.pop_front();
                start          <= 1'b1;
                i_func         <= drv_cmd.func;
                i_meth_count   <= drv_cmd.meth;
                i_unmeth_count <= drv_cmd.unmeth;
                i_mask_bit     <= drv_cmd.mbit;
                i_state_index  <= drv_cmd.sidx;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // monitor
    t_summary_row want_row;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (rows_due.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected row: expected none actual bin %0d", $time, o_bin_id);
            end else begin
                want_row = rows_due.pop_front();
                check_field("bin_id", want_row.bin, o_bin_id);
                check_field("universe_count", want_row.universe, o_universe_count);
                check_field("query_count", want_row.query, o_query_count);
                check_field("mask_count", want_row.members, o_mask_count);
                check_field("overlap_count", want_row.overlap, o_overlap_count);
                check_field("mean_ratio", want_row.mean, o_mean_ratio);
                check_field("status", want_row.status, o_status);
                check_field("last", want_row.last, o_last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic push_site(logic [CNT_W-1:0] m, logic [CNT_W-1:0] u, logic mb,
                             logic [BIN_W-1:0] idx);
        items_to_send.push_back('{FUNC_SITE, m, u, mb, idx});
        n_queued++;
    endtask

    task automatic push_finish();
        items_to_send.push_back('{FUNC_FINISH, CNT_W'($urandom), CNT_W'($urandom),
                                  1'($urandom), BIN_W'($urandom)});
        n_queued++;
    endtask

    task automatic settle();
        while (n_accepted != n_queued || busy || rows_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return CNT_MAX;
            2: return CNT_W'($urandom);
            3: return CNT_MAX - CNT_W'($urandom_range(0, 3));
            default: return CNT_W'($urandom_range(0, 200));
        endcase
    endfunction

    initial begin : stimulus
        int               random_sent;
        int               n;
        int unsigned      nb;
        logic [MODE_W-1:0] mode;
        logic [NST_W-1:0]  ns;
        logic [BIN_W-1:0]  idx;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, no mask; empty run first, then count extremes
        push_finish();
        push_site('0, '0, 1'b0, '0);
        push_site(CNT_MAX, '0, 1'b0, '0);
        push_site('0, CNT_MAX, 1'b1, '0);
        push_site(CNT_MAX, CNT_MAX, 1'b0, 5'd31);
        push_site(CNT_W'(1), CNT_MAX, 1'b1, 5'd31);
        push_finish();
        settle();

        // binary mask, unused data bits set
        write_reg(REG_MASK_MODE, {4'b1111, MODE_BINARY});
        push_site(CNT_W'(5), CNT_W'(3), 1'b1, '0);
        push_site('0, '0, 1'b1, '0);
        push_site(CNT_W'(7), CNT_W'(7), 1'b0, '0);
        push_finish();
        settle();

        // state mode, all 32 bins
        write_reg(REG_MASK_MODE, {4'b0000, MODE_STATE});
        write_reg(REG_NUM_STATES, NST_W'(32));
        push_site(CNT_MAX, CNT_W'(1), 1'b0, '0);
        push_site(CNT_W'(3), CNT_W'(1), 1'b1, 5'd31);
        push_site('0, '0, 1'b0, 5'd31);
        push_finish();
        settle();

        // zero bins clamps to one; out of range index
        write_reg(REG_NUM_STATES, '0);
        push_site(CNT_W'(1), CNT_W'(1), 1'b0, '0);
        push_site(CNT_W'(2), CNT_W'(2), 1'b0, 5'd1);
        push_finish();
        settle();

        // mode change with sites still held, then selector three
        write_reg(REG_NUM_STATES, NST_W'(4));
        push_site(CNT_W'(9), CNT_W'(1), 1'b0, 5'd3);
        push_site(CNT_W'(1), CNT_W'(1), 1'b0, 5'd2);
        settle();
        write_reg(REG_MASK_MODE, {4'b1010, 2'd3});
        write_reg(REG_NUM_STATES, NST_W'(63));
        push_site(CNT_W'(4), CNT_W'(4), 1'b1, 5'd7);
        push_site('0, '0, 1'b0, '0);
        push_finish();
        settle();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            mode = MODE_W'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0) mode = MODE_STATE;
            case ($urandom_range(0, 6))
                0: ns = '0;
                1: ns = NST_W'(1);
                2: ns = NST_W'(32);
                3: ns = NST_W'($urandom_range(33, 63));
                default: ns = NST_W'($urandom_range(2, 8));
            endcase
            write_reg(REG_MASK_MODE, {4'($urandom), mode});
            write_reg(REG_NUM_STATES, ns);
            nb = bin_count(ns);
            n = $urandom_range(4, 30);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 24) == 0) begin
                    push_finish();
                end else begin
                    if ($urandom_range(0, 9) == 0) idx = BIN_W'($urandom);
                    else idx = BIN_W'($urandom_range(0, nb - 1));
                    if ($urandom_range(0, 7) == 0) push_site('0, '0, 1'($urandom), idx);
                    else push_site(pick_count(), pick_count(), 1'($urandom), idx);
                end
            end
            // sometimes carry the stores across the next register change
            if ($urandom_range(0, 4) != 0) push_finish();
            random_sent += n + 1;
            settle();
        end
        push_finish();
        settle();

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
